[src/haversine_distance_defines.svh]
// Assertion macros used by the haversine distance RTL
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// check cons in the same cycle as ante
`define HAV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine_distance assertion failed");

// check cons in the cycle after ante
`define HAV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haversine_distance assertion failed");

`endif

[src/hav_pkg.sv]
// Constants, types and helper functions of the haversine distance block
package hav_pkg;

    localparam int NUM_STEPS = 24;
    localparam int FRAC = 24;
    localparam int ROOT_STEPS = FRAC + 1;
    localparam int NUM_LANES = 4;

    localparam logic signed [31:0] ONE_F = 32'sd16777216;
    localparam logic signed [31:0] PI_F = 32'sd52707179;
    localparam logic signed [31:0] HALF_PI_F = 32'sd26353589;
    localparam logic signed [31:0] TWO_PI_F = 32'sd105414357;
    localparam logic signed [31:0] GAIN_START = 32'sd10188013;
    localparam logic [29:0] DEG_RAD_K = 30'd599690565;
    localparam int DEG_SHIFT = 35;

    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [33:0] DIST_MAX = 34'h3_FFFF_FFFF;

    localparam logic REG_RADIUS = 1'b0;

    typedef enum logic [1:0] {
        LANE_DLAT = 2'd0,
        LANE_DLON = 2'd1,
        LANE_LAT1 = 2'd2,
        LANE_LAT2 = 2'd3
    } lane_t;

    typedef logic signed [31:0] fix_t;

    function automatic fix_t atan_entry(input int idx);
        fix_t res;
        case (idx)
            0: res = 32'sd13176795;
            1: res = 32'sd7778716;
            2: res = 32'sd4110060;
            3: res = 32'sd2086331;
            4: res = 32'sd1047214;
            5: res = 32'sd524117;
            6: res = 32'sd262123;
            7: res = 32'sd131069;
            8: res = 32'sd65536;
            default: res = 32'sd1 <<< (FRAC - idx);
        endcase
        return res;
    endfunction

    function automatic fix_t round_frac(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return t[31:0];
    endfunction

endpackage

[src/haversine_distance.sv]
// Pipelined haversine great-circle distance between two waypoints
//
// Usage:
//   Input channel in_valid/in_ready carries one waypoint pair per transfer:
//   latitudes and longitudes in degrees times 2^24, two's complement.
//   Output channel out_valid/out_ready carries distance_metres, metres times
//   2^8, saturated at 2^34-1.
//   The APB port holds sphere_radius_m at byte address 0 (pready always high).
//   Throughput: one pair per cycle while nothing stalls; every stage is a
//   register with its own valid bit, so 84 pairs may be in flight.
//   A stalled receiver holds the output register; earlier stages keep
//   advancing into empty slots, so in_ready stays high until every stage
//   is full.
//   Reset empties the pipeline and loads the radius with 6371000.
//   Write the radius only while no transfer is in flight.
`include "haversine_distance_defines.svh"

module haversine_distance
    import hav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] first_latitude,
    input  logic signed [32:0] first_longitude,
    input  logic signed [31:0] second_latitude,
    input  logic signed [32:0] second_longitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [33:0]        distance_metres,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ST_IN = 0;
    localparam int ST_DIFF = 1;
    localparam int ST_MUL = 2;
    localparam int ST_RAD = 3;
    localparam int ST_WRAP = 4;
    localparam int ST_FOLD = 5;
    localparam int ST_ROT = 6;
    localparam int ST_SQR = ST_ROT + NUM_STEPS;
    localparam int ST_TERM = ST_SQR + 1;
    localparam int ST_SUM = ST_SQR + 2;
    localparam int ST_ROOT = ST_SUM + 1;
    localparam int ST_VEC = ST_ROOT + ROOT_STEPS;
    localparam int ST_SCALE = ST_VEC + NUM_STEPS;
    localparam int ST_OUT = ST_SCALE + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    logic              vld_reg [NUM_STAGES];
    logic              adv [NUM_STAGES];
    logic [23:0]       radius_reg;
    logic              cfg_write;

    // stage data
    logic signed [31:0] lat1_reg, lat2_reg;
    logic signed [32:0] lon1_reg, lon2_reg;
    logic [33:0]        mag_reg [NUM_LANES];
    logic               neg_reg [NUM_LANES];
    logic [46:0]        plo_reg [NUM_LANES];
    logic [46:0]        phi_reg [NUM_LANES];
    logic               mneg_reg [NUM_LANES];
    fix_t               th_reg [NUM_LANES];
    fix_t               wth_reg [NUM_LANES];
    fix_t               cx_reg [NUM_STEPS + 1][NUM_LANES];
    fix_t               cy_reg [NUM_STEPS + 1][NUM_LANES];
    fix_t               cz_reg [NUM_STEPS + 1][NUM_LANES];
    logic               flip_reg [NUM_STEPS + 1][NUM_LANES];
    fix_t               sl2_reg, sn2_reg, cc_reg, sl2d_reg, term_reg;
    logic [24:0]        sq_val_reg [ROOT_STEPS + 1][2];
    logic [25:0]        sq_root_reg [ROOT_STEPS + 1][2];
    logic [27:0]        sq_rem_reg [ROOT_STEPS + 1][2];
    fix_t               vx_reg [NUM_STEPS];
    fix_t               vy_reg [NUM_STEPS];
    fix_t               vz_reg [NUM_STEPS];
    logic [50:0]        prod_reg;
    logic [33:0]        dist_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_RADIUS) ? {8'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_RADIUS))
        begin
            radius_reg <= pwdata[23:0];
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv[NUM_STAGES - 1] = !vld_reg[NUM_STAGES - 1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    assign in_ready = adv[ST_IN];
    assign out_valid = vld_reg[ST_OUT];
    assign distance_metres = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv[ST_IN])
            begin
                vld_reg[ST_IN] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // capture the transfer
    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
        begin
            lat1_reg <= first_latitude;
            lon1_reg <= first_longitude;
            lat2_reg <= second_latitude;
            lon2_reg <= second_longitude;
        end
    end

    // differences and latitudes, split into sign and magnitude
    logic signed [33:0] lane_next [NUM_LANES];
    always_comb
    begin
        lane_next[LANE_DLAT] = {{2{lat2_reg[31]}}, lat2_reg} - {{2{lat1_reg[31]}}, lat1_reg};
        lane_next[LANE_DLON] = {lon2_reg[32], lon2_reg} - {lon1_reg[32], lon1_reg};
        lane_next[LANE_LAT1] = {{2{lat1_reg[31]}}, lat1_reg};
        lane_next[LANE_LAT2] = {{2{lat2_reg[31]}}, lat2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIFF])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                neg_reg[l] <= lane_next[l][33];
                mag_reg[l] <= lane_next[l][33] ? 34'(-lane_next[l]) : 34'(lane_next[l]);
            end
        end
    end

    // degree to radian partial products
    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                plo_reg[l] <= 47'(mag_reg[l][16:0] * DEG_RAD_K);
                phi_reg[l] <= 47'(mag_reg[l][33:17] * DEG_RAD_K);
                mneg_reg[l] <= neg_reg[l];
            end
        end
    end

    // sum, round, restore the sign; half differences shift one more
    logic [64:0] rad_sum [NUM_LANES];
    logic [64:0] rad_abs [NUM_LANES];
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rad_sum[l] = {1'b0, phi_reg[l], 17'd0} + {18'd0, plo_reg[l]};
            if (l == LANE_DLAT || l == LANE_DLON)
            begin
                rad_abs[l] = (rad_sum[l] + (65'd1 << DEG_SHIFT)) >> (DEG_SHIFT + 1);
            end
            else
            begin
                rad_abs[l] = (rad_sum[l] + (65'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_RAD])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                th_reg[l] <= mneg_reg[l] ? -fix_t'({1'b0, rad_abs[l][30:0]})
                                         : fix_t'({1'b0, rad_abs[l][30:0]});
            end
        end
    end

    // reduce by a full turn
    always_ff @(posedge clk)
    begin
        if (adv[ST_WRAP])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (th_reg[l] > PI_F)
                begin
                    wth_reg[l] <= th_reg[l] - TWO_PI_F;
                end
                else if (th_reg[l] < -PI_F)
                begin
                    wth_reg[l] <= th_reg[l] + TWO_PI_F;
                end
                else
                begin
                    wth_reg[l] <= th_reg[l];
                end
            end
        end
    end

    // reflect into the right half plane
    always_ff @(posedge clk)
    begin
        if (adv[ST_FOLD])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                cx_reg[0][l] <= GAIN_START;
                cy_reg[0][l] <= '0;
                if (wth_reg[l] > HALF_PI_F)
                begin
                    cz_reg[0][l] <= PI_F - wth_reg[l];
                    flip_reg[0][l] <= 1'b1;
                end
                else if (wth_reg[l] < -HALF_PI_F)
                begin
                    cz_reg[0][l] <= -PI_F - wth_reg[l];
                    flip_reg[0][l] <= 1'b1;
                end
                else
                begin
                    cz_reg[0][l] <= wth_reg[l];
                    flip_reg[0][l] <= 1'b0;
                end
            end
        end
    end

    // rotation micro-steps, one per stage
    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (adv[ST_ROT + i])
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    flip_reg[i + 1][l] <= flip_reg[i][l];
                    if (!cz_reg[i][l][31])
                    begin
                        cx_reg[i + 1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                        cy_reg[i + 1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                        cz_reg[i + 1][l] <= cz_reg[i][l] - atan_entry(i);
                    end
                    else
                    begin
                        cx_reg[i + 1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                        cy_reg[i + 1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                        cz_reg[i + 1][l] <= cz_reg[i][l] + atan_entry(i);
                    end
                end
            end
        end
    end

    // squares and cosine product
    fix_t cos1, cos2;
    assign cos1 = flip_reg[NUM_STEPS][LANE_LAT1] ? -cx_reg[NUM_STEPS][LANE_LAT1]
                                                 : cx_reg[NUM_STEPS][LANE_LAT1];
    assign cos2 = flip_reg[NUM_STEPS][LANE_LAT2] ? -cx_reg[NUM_STEPS][LANE_LAT2]
                                                 : cx_reg[NUM_STEPS][LANE_LAT2];

    always_ff @(posedge clk)
    begin
        if (adv[ST_SQR])
        begin
            sl2_reg <= round_frac(64'(cy_reg[NUM_STEPS][LANE_DLAT])
                                  * 64'(cy_reg[NUM_STEPS][LANE_DLAT]));
            sn2_reg <= round_frac(64'(cy_reg[NUM_STEPS][LANE_DLON])
                                  * 64'(cy_reg[NUM_STEPS][LANE_DLON]));
            cc_reg <= round_frac(64'(cos1) * 64'(cos2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_TERM])
        begin
            term_reg <= round_frac(64'(sn2_reg) * 64'(cc_reg));
            sl2d_reg <= sl2_reg;
        end
    end

    // a, clamped to [0, 1], and 1 - a
    logic signed [32:0] a_sum;
    logic [24:0]        a_clamp;
    always_comb
    begin
        a_sum = 33'(sl2d_reg) + 33'(term_reg);
        if (a_sum[32])
        begin
            a_clamp = '0;
        end
        else if (a_sum > 33'(ONE_F))
        begin
            a_clamp = ONE_F[24:0];
        end
        else
        begin
            a_clamp = a_sum[24:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_SUM])
        begin
            sq_val_reg[0][0] <= a_clamp;
            sq_val_reg[0][1] <= ONE_F[24:0] - a_clamp;
            for (int r = 0; r < 2; r++)
            begin
                sq_root_reg[0][r] <= '0;
                sq_rem_reg[0][r] <= '0;
            end
        end
    end

    // square roots, one result bit per stage
    for (genvar s = 0; s < ROOT_STEPS; s++)
    begin : g_root
        localparam int PAIR = ROOT_STEPS - 1 - s;
        logic [49:0] padded [2];
        logic [27:0] shifted [2];
        logic [27:0] trial [2];
        always_comb
        begin
            for (int r = 0; r < 2; r++)
            begin
                padded[r] = {1'b0, sq_val_reg[s][r], 24'd0};
                shifted[r] = {sq_rem_reg[s][r][25:0], padded[r][2 * PAIR + 1 -: 2]};
                trial[r] = {sq_root_reg[s][r], 2'b01};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_ROOT + s])
            begin
                for (int r = 0; r < 2; r++)
                begin
                    sq_val_reg[s + 1][r] <= sq_val_reg[s][r];
                    if (shifted[r] >= trial[r])
                    begin
                        sq_rem_reg[s + 1][r] <= shifted[r] - trial[r];
                        sq_root_reg[s + 1][r] <= {sq_root_reg[s][r][24:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg[s + 1][r] <= shifted[r];
                        sq_root_reg[s + 1][r] <= {sq_root_reg[s][r][24:0], 1'b0};
                    end
                end
            end
        end
    end

    // vectoring micro-steps for the central angle
    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_vec
        fix_t src_x, src_y, src_z;
        if (i == 0)
        begin : g_first
            assign src_x = fix_t'({6'd0, sq_root_reg[ROOT_STEPS][1]});
            assign src_y = fix_t'({6'd0, sq_root_reg[ROOT_STEPS][0]});
            assign src_z = '0;
        end
        else
        begin : g_next
            assign src_x = vx_reg[i - 1];
            assign src_y = vy_reg[i - 1];
            assign src_z = vz_reg[i - 1];
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_VEC + i])
            begin
                if (!src_y[31])
                begin
                    vx_reg[i] <= src_x + (src_y >>> i);
                    vy_reg[i] <= src_y - (src_x >>> i);
                    vz_reg[i] <= src_z + atan_entry(i);
                end
                else
                begin
                    vx_reg[i] <= src_x - (src_y >>> i);
                    vy_reg[i] <= src_y + (src_x >>> i);
                    vz_reg[i] <= src_z - atan_entry(i);
                end
            end
        end
    end

    // radius times twice the angle
    logic [26:0] ang2;
    assign ang2 = vz_reg[NUM_STEPS - 1][31] ? 27'd0 : {vz_reg[NUM_STEPS - 1][25:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv[ST_SCALE])
        begin
            prod_reg <= 51'(radius_reg * ang2);
        end
    end

    // round to 8 fraction bits and saturate
    logic [51:0] dist_round;
    assign dist_round = {1'b0, prod_reg} + (52'd1 << (FRAC - 9));

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            if (|dist_round[51:FRAC + 26])
            begin
                dist_reg <= DIST_MAX;
            end
            else
            begin
                dist_reg <= dist_round[FRAC + 25:FRAC - 8];
            end
        end
    end

    `HAV_ASSERT_SAME(a_empty_entry_ready, !vld_reg[ST_IN], in_ready)
    `HAV_ASSERT_SAME(a_drain_all_ready, out_ready, in_ready)
    `HAV_ASSERT_NEXT(a_last_stage_fills, vld_reg[ST_SCALE] && adv[ST_OUT], out_valid)
    `HAV_ASSERT_NEXT(a_radius_write, cfg_write && (paddr[2] == REG_RADIUS), radius_reg == $past(pwdata[23:0]))

endmodule

[tb/sv/haversine_distance_tb.sv]
// Self-checking testbench for the pipelined haversine distance block
`timescale 1ns / 100ps

module testbench;
    import hav_pkg::*;

    localparam int ANGLE_BITS = 24;
    localparam int ARC_STEPS = 24;
    localparam logic [2:0] RADIUS_ADDR = 3'd0;
    localparam longint unsigned RADIUS_MASK = 64'hFF_FFFF;
    localparam longint unsigned DIST_LIMIT = (64'd1 << 34) - 1;
    localparam longint DEG = 64'd16777216;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {CHECK_OK, CHECK_EXTRA, CHECK_WRONG} check_t;

    class distance_scoreboard;
        longint arc_tab[ARC_STEPS];
        longint pi_f, half_pi_f, two_pi_f, gain_start;
        longint unsigned deg_k;
        longint unsigned radius;
        longint unsigned pending_distances[$];

        function longint unsigned atan_inv(longint unsigned m);
            longint unsigned term, sum, q, k;
            term = (64'd1 << 62) / m;
            sum = 0;
            k = 0;
            while (term != 0)
            begin
                q = term / (2 * k + 1);
                if (k[0]) sum -= q; else sum += q;
                term = term / m / m;
                k++;
            end
            return sum;
        endfunction

        function longint unsigned round62(longint unsigned v, int s);
            return (v + (64'd1 << (s - 1))) >> s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function new();
            longint unsigned quarter, k2;
            quarter = atan_inv(2) + atan_inv(3);
            arc_tab[0] = round62(quarter, 62 - ANGLE_BITS);
            for (int i = 1; i < ARC_STEPS; i++)
                arc_tab[i] = round62(atan_inv(64'd1 << i), 62 - ANGLE_BITS);
            pi_f = round62(quarter, 60 - ANGLE_BITS);
            half_pi_f = round62(quarter, 61 - ANGLE_BITS);
            two_pi_f = round62(quarter, 59 - ANGLE_BITS);
            deg_k = (quarter + 45 * (64'd1 << 26)) / (45 * (64'd1 << 27));
            k2 = 64'd1 << 62;
            for (int i = 0; i < ARC_STEPS; i++)
                k2 -= k2 / ((64'd1 << (2 * i)) + 1);
            gain_start = int_sqrt(k2 >> (62 - 2 * ANGLE_BITS));
            radius = RADIUS_RESET;
        endfunction

        function longint round_fix(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint to_radians(longint v, int extra);
            int sh;
            longint unsigned mag, r;
            sh = 59 - ANGLE_BITS + extra;
            mag = v < 0 ? -v : v;
            r = (mag * deg_k + (64'd1 << (sh - 1))) >> sh;
            return v < 0 ? -longint'(r) : longint'(r);
        endfunction

        function void rotate(longint th, output longint s, output longint c);
            longint x, y, dx, dy;
            bit flip;
            flip = 0;
            x = gain_start;
            y = 0;
            if (th > pi_f) th -= two_pi_f;
            else if (th < -pi_f) th += two_pi_f;
            if (th > half_pi_f)
            begin
                th = pi_f - th;
                flip = 1;
            end
            else if (th < -half_pi_f)
            begin
                th = -pi_f - th;
                flip = 1;
            end
            for (int i = 0; i < ARC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (th >= 0)
                begin
                    x -= dx; y += dy; th -= arc_tab[i];
                end
                else
                begin
                    x += dx; y -= dy; th += arc_tab[i];
                end
            end
            s = y;
            c = flip ? -x : x;
        endfunction

        function longint vector_angle(longint x, longint y);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < ARC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += arc_tab[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= arc_tab[i];
                end
            end
            return z;
        endfunction

        function longint unsigned great_circle_distance(longint lat1, longint lon1,
                                                        longint lat2, longint lon2);
            longint one, s_lat, s_lon, c1, c2, junk, a, ang;
            longint unsigned ry, rx, span;
            one = 64'sd1 <<< ANGLE_BITS;
            rotate(to_radians(lat2 - lat1, 1), s_lat, junk);
            rotate(to_radians(lon2 - lon1, 1), s_lon, junk);
            rotate(to_radians(lat1, 0), junk, c1);
            rotate(to_radians(lat2, 0), junk, c2);
            a = round_fix(s_lat * s_lat, ANGLE_BITS)
              + round_fix(round_fix(s_lon * s_lon, ANGLE_BITS)
                          * round_fix(c1 * c2, ANGLE_BITS), ANGLE_BITS);
            if (a < 0) a = 0;
            if (a > one) a = one;
            ry = int_sqrt(longint'(a) << ANGLE_BITS);
            rx = int_sqrt(longint'(one - a) << ANGLE_BITS);
            ang = vector_angle(rx, ry);
            if (ang < 0) ang = 0;
            ang *= 2;
            span = (radius * ang + (64'd1 << (ANGLE_BITS - 9))) >> (ANGLE_BITS - 8);
            if (span > DIST_LIMIT) span = DIST_LIMIT;
            return span;
        endfunction

        function void note_pair(logic signed [31:0] lat1, logic signed [32:0] lon1,
                                logic signed [31:0] lat2, logic signed [32:0] lon2);
            pending_distances.push_back(great_circle_distance(lat1, lon1, lat2, lon2));
        endfunction

        function check_t check_distance(logic [33:0] got, output longint unsigned want);
            want = 0;
            if (pending_distances.size() == 0) return CHECK_EXTRA;
            want = pending_distances.pop_front();
            return (want == got) ? CHECK_OK : CHECK_WRONG;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] first_latitude = '0;
    logic signed [32:0] first_longitude = '0;
    logic signed [31:0] second_latitude = '0;
    logic signed [32:0] second_longitude = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [33:0] distance_metres;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    int errors = 0;
    bit steady = 0;
    distance_scoreboard sb = new();

    haversine_distance dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        check_t st;
        longint unsigned want;
        if (rst_n && out_valid && out_ready)
        begin
            st = sb.check_distance(distance_metres, want);
            if (st == CHECK_EXTRA) report("unexpected distance", distance_metres, 0);
            else if (st == CHECK_WRONG) report("distance_metres", distance_metres, want);
        end
        out_ready <= rst_n && (steady || $urandom_range(0, 99) >= 36);
    end

    task automatic send_pair(longint lat1, longint lon1, longint lat2, longint lon2);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_latitude <= 32'(lat1);
        first_longitude <= 33'(lon1);
        second_latitude <= 32'(lat2);
        second_longitude <= 33'(lon2);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pair(32'(lat1), 33'(lon1), 32'(lat2), 33'(lon2));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_radius(longint unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RADIUS_ADDR;
        pwdata <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.radius = value & RADIUS_MASK;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & RADIUS_MASK) != sb.radius) report("radius readback", prdata, sb.radius);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pairs(int count);
        logic signed [31:0] lat1, lat2;
        logic signed [32:0] lon1, lon2;
        longint unsigned w;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    lat1 = $urandom;
                    lat2 = $urandom;
                    lon1 = 33'({$urandom_range(0, 1), $urandom});
                    lon2 = 33'({$urandom_range(0, 1), $urandom});
                end
                2, 3:
                begin
                    lat1 = 32'(longint'($urandom_range(0, 3019898880)) - 1509949440);
                    lon1 = 33'(longint'({$urandom_range(0, 1), $urandom} % 6039797761)
                               - 3019898880);
                    lat2 = 32'(longint'(lat1) + longint'($urandom_range(0, 2000000))
                               - 1000000);
                    lon2 = 33'(longint'(lon1) + longint'($urandom_range(0, 2000000))
                               - 1000000);
                end
                default:
                begin
                    lat1 = 32'(longint'($urandom_range(0, 3019898880)) - 1509949440);
                    lat2 = 32'(longint'($urandom_range(0, 3019898880)) - 1509949440);
                    w = {$urandom_range(0, 1), $urandom};
                    lon1 = 33'(longint'(w % 6039797761) - 3019898880);
                    w = {$urandom_range(0, 1), $urandom};
                    lon2 = 33'(longint'(w % 6039797761) - 3019898880);
                end
            endcase
            send_pair(lat1, lon1, lat2, lon2);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_radius(RADIUS_RESET);
        send_pair(0, 0, 0, 0);
        send_pair(90 * DEG, 0, -90 * DEG, 0);
        send_pair(0, 0, 0, 180 * DEG);
        send_pair(0, -180 * DEG, 0, 180 * DEG);
        send_pair(-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG);
        send_pair(0, 180 * DEG, 0, -180 * DEG);
        send_pair(32'h7fff_ffff, 33'h0_ffff_ffff, 32'h8000_0000, 33'h1_0000_0000);
        send_pair(32'h8000_0000, 33'h1_0000_0000, 32'h7fff_ffff, 33'h0_ffff_ffff);
        send_pair(45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG + 1);
        send_pair(1, 1, 0, 0);
        send_pair(-1, -1, 1, 1);
        send_pair(0, 0, 0, 90 * DEG);
        send_pair(0, 0, 90 * DEG, 0);
        send_pair(60 * DEG, 30 * DEG, -30 * DEG, -150 * DEG);
        send_pair(90 * DEG, 0, 90 * DEG, 180 * DEG);
        send_pair(0, 0, 0, 180 * DEG - 1);
        send_pair(-90 * DEG, 0, -90 * DEG + 1, 0);
        send_pair(30 * DEG, -170 * DEG, 30 * DEG, 170 * DEG);
        random_pairs(300);
        steady = 1;
        random_pairs(150);
        steady = 0;
        drain();

        set_radius(1);
        random_pairs(150);
        drain();
        random_pairs(150);
        drain();

        set_radius(RADIUS_MASK);
        send_pair(0, 0, 0, 180 * DEG);
        send_pair(90 * DEG, 0, -90 * DEG, 0);
        random_pairs(350);
        drain();

        set_radius(0);
        random_pairs(100);
        drain();

        set_radius($urandom_range(1, 16777215));
        random_pairs(300);
        drain();

        set_radius(RADIUS_RESET);
        random_pairs(300);
        drain();

        if (errors == 0)
            $display("haversine_distance test passed");
        else
            $display("haversine_distance test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("haversine_distance test failed");
        $finish;
    end
endmodule
